/* sv/nspm_pkg.sv */
`timescale 1ns / 1ps

package nspm_pkg;

    // Largest supported source side and target side.
    localparam int MAX_SOURCE_SIDE = 128;
    localparam int MAX_TARGET_SIDE = 128;

    // Field and register widths.
    localparam int COORD_W = 7;
    localparam int SIZE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int CHAN_W  = 8;

    // Source coordinates and store address.
    localparam int SRC_IDX_W   = $clog2(MAX_SOURCE_SIDE);
    localparam int ADDR_W      = 2 * SRC_IDX_W;
    localparam int STORE_DEPTH = MAX_SOURCE_SIDE * MAX_SOURCE_SIDE;

    // For a fetch inside the target, coordinate * size / target stays below the source size.
    localparam int QW        = SRC_IDX_W;
    localparam int REM_W     = SIZE_W;
    localparam int PROD_W    = QW + REM_W;
    localparam int DIV_STEPS = QW;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes on the input tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_TARGET_SIDE   = 2'd2;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_FETCH,
        KIND_MISS
    } t_kind;

    // Effective sizes, already saturated to their legal ranges.
    typedef struct packed {
        logic [SIZE_W-1:0] src_w;
        logic [SIZE_W-1:0] src_h;
        logic [SIZE_W-1:0] target;
    } t_cfg;

    // One queued command from the front part.
    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
        logic [PROD_W-1:0] nx;
        logic [PROD_W-1:0] ny;
    } t_cmd;

    // One lane of the restoring divider: partial remainder and dividend/quotient bits.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QW-1:0]    work;
    } t_lane;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
        t_lane             lx;
        t_lane             ly;
    } t_div_stage;

endpackage

/* sv/nspm_front.sv */
`timescale 1ns / 1ps

module nspm_front (
    input  nspm_pkg::t_cfg                 i_cfg,
    input  logic                           i_valid,
    input  logic                           i_op,
    input  logic [nspm_pkg::COORD_W-1:0]   i_column,
    input  logic [nspm_pkg::COORD_W-1:0]   i_row,
    input  logic [nspm_pkg::WORD_W-1:0]    i_word,
    input  logic                           i_full,
    output logic                           o_ready,
    output logic                           o_push,
    output nspm_pkg::t_cmd                 o_cmd
);
    import nspm_pkg::*;

    logic accept;
    logic src_hit;
    logic tgt_hit;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    assign src_hit = (SIZE_W'(i_column) < i_cfg.src_w) && (SIZE_W'(i_row) < i_cfg.src_h);
    // A target side of zero makes both compares fail, so every fetch misses.
    assign tgt_hit = (SIZE_W'(i_column) < i_cfg.target) && (SIZE_W'(i_row) < i_cfg.target);

    // Writes outside the source image are dropped here and never queued.
    assign o_push = accept && ((i_op == OP_FETCH) || src_hit);

    always_comb begin
        o_cmd.addr = {i_row[SRC_IDX_W-1:0], i_column[SRC_IDX_W-1:0]};
        o_cmd.word = i_word;
        o_cmd.nx   = PROD_W'(i_column) * PROD_W'(i_cfg.src_w);
        o_cmd.ny   = PROD_W'(i_row) * PROD_W'(i_cfg.src_h);
        if (i_op == OP_WRITE) begin
            o_cmd.kind = KIND_WRITE;
        end else if (tgt_hit) begin
            o_cmd.kind = KIND_FETCH;
        end else begin
            o_cmd.kind = KIND_MISS;
        end
    end

endmodule

/* sv/nspm_queue.sv */
`timescale 1ns / 1ps

module nspm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  nspm_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output nspm_pkg::t_cmd o_head,
    output logic           o_empty,
    output logic           o_full
);
    import nspm_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_head  = r_slot[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |=> r_wr_ptr == $past(r_wr_ptr))
        else $error("queue overwritten while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue popped while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond its depth");
`endif

endmodule

/* sv/nspm_back.sv */
`timescale 1ns / 1ps

module nspm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nspm_pkg::t_cfg                i_cfg,
    input  nspm_pkg::t_cmd                i_head,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [nspm_pkg::CHAN_W-1:0]   o_red,
    output logic [nspm_pkg::CHAN_W-1:0]   o_green,
    output logic [nspm_pkg::CHAN_W-1:0]   o_blue,
    output logic [nspm_pkg::CHAN_W-1:0]   o_alpha,
    output logic                          o_in_range
);
    import nspm_pkg::*;

    // One step of restoring division: bring down the next dividend bit,
    // subtract the divisor when it fits and shift in the quotient bit.
    function automatic t_lane div_step(t_lane l, logic [SIZE_W-1:0] d);
        logic [REM_W:0] trial;
        t_lane          n;
        trial  = {l.rem, l.work[QW-1]};
        n.work = {l.work[QW-2:0], 1'b0};
        if (trial >= {1'b0, d}) begin
            n.rem     = REM_W'(trial - {1'b0, d});
            n.work[0] = 1'b1;
        end else begin
            n.rem = trial[REM_W-1:0];
        end
        return n;
    endfunction

    // Exact floor(x / 255) for every product of two bytes.
    function automatic logic [CHAN_W-1:0] div255(logic [2*CHAN_W-1:0] x);
        logic [2*CHAN_W-1:0] s;
        s = x + (2*CHAN_W)'(1) + {{CHAN_W{1'b0}}, x[2*CHAN_W-1:CHAN_W]};
        return s[2*CHAN_W-1:CHAN_W];
    endfunction

    logic en;

    t_div_stage r_div [DIV_STEPS+1];

    logic [WORD_W-1:0] r_store [STORE_DEPTH];
    logic [WORD_W-1:0] r_rd_data;
    logic              r_mem_valid;
    t_kind             r_mem_kind;

    logic [CHAN_W-1:0]   mul_alpha;
    logic [CHAN_W-1:0]   mul_r;
    logic [CHAN_W-1:0]   mul_g;
    logic [CHAN_W-1:0]   mul_b;
    logic [2*CHAN_W-1:0] r_prod_r;
    logic [2*CHAN_W-1:0] r_prod_g;
    logic [2*CHAN_W-1:0] r_prod_b;
    logic [CHAN_W-1:0]   r_prod_a;
    logic                r_prod_valid;
    logic                r_prod_in;

    logic              r_out_valid;
    logic [CHAN_W-1:0] r_out_red;
    logic [CHAN_W-1:0] r_out_green;
    logic [CHAN_W-1:0] r_out_blue;
    logic [CHAN_W-1:0] r_out_alpha;
    logic              r_out_in_range;

    // The whole pipeline moves together; it holds only while a result waits.
    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DIV_STEPS; i++) begin
                r_div[i].valid <= 1'b0;
            end
        end else if (en) begin
            r_div[0].valid   <= !i_empty;
            r_div[0].kind    <= i_head.kind;
            r_div[0].addr    <= i_head.addr;
            r_div[0].word    <= i_head.word;
            r_div[0].lx.rem  <= i_head.nx[PROD_W-1:QW];
            r_div[0].lx.work <= i_head.nx[QW-1:0];
            r_div[0].ly.rem  <= i_head.ny[PROD_W-1:QW];
            r_div[0].ly.work <= i_head.ny[QW-1:0];
            for (int i = 0; i < DIV_STEPS; i++) begin
                r_div[i+1].valid <= r_div[i].valid;
                r_div[i+1].kind  <= r_div[i].kind;
                r_div[i+1].addr  <= r_div[i].addr;
                r_div[i+1].word  <= r_div[i].word;
                r_div[i+1].lx    <= div_step(r_div[i].lx, i_cfg.target);
                r_div[i+1].ly    <= div_step(r_div[i].ly, i_cfg.target);
            end
        end
    end

    // Writes and reads share one stage, so a fetch always sees every earlier write.
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_div[DIV_STEPS].valid && (r_div[DIV_STEPS].kind == KIND_WRITE)) begin
                r_store[r_div[DIV_STEPS].addr] <= r_div[DIV_STEPS].word;
            end
            r_rd_data <= r_store[{r_div[DIV_STEPS].ly.work, r_div[DIV_STEPS].lx.work}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_valid <= 1'b0;
        end else if (en) begin
            r_mem_valid <= r_div[DIV_STEPS].valid && (r_div[DIV_STEPS].kind != KIND_WRITE);
            r_mem_kind  <= r_div[DIV_STEPS].kind;
        end
    end

    // A miss forces every channel to zero before the multipliers.
    always_comb begin
        if (r_mem_kind == KIND_FETCH) begin
            mul_r     = r_rd_data[7:0];
            mul_g     = r_rd_data[15:8];
            mul_b     = r_rd_data[23:16];
            mul_alpha = r_rd_data[31:24];
        end else begin
            mul_r     = '0;
            mul_g     = '0;
            mul_b     = '0;
            mul_alpha = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else if (en) begin
            r_prod_valid <= r_mem_valid;
            r_prod_in    <= (r_mem_kind == KIND_FETCH);
            r_prod_r     <= (2*CHAN_W)'(mul_r) * (2*CHAN_W)'(mul_alpha);
            r_prod_g     <= (2*CHAN_W)'(mul_g) * (2*CHAN_W)'(mul_alpha);
            r_prod_b     <= (2*CHAN_W)'(mul_b) * (2*CHAN_W)'(mul_alpha);
            r_prod_a     <= mul_alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid    <= r_prod_valid;
            r_out_red      <= div255(r_prod_r);
            r_out_green    <= div255(r_prod_g);
            r_out_blue     <= div255(r_prod_b);
            r_out_alpha    <= r_prod_a;
            r_out_in_range <= r_prod_in;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_red      = r_out_red;
    assign o_green    = r_out_green;
    assign o_blue     = r_out_blue;
    assign o_alpha    = r_out_alpha;
    assign o_in_range = r_out_in_range;

`ifndef SYNTHESIS
    a_col_in_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div[DIV_STEPS].valid && (r_div[DIV_STEPS].kind == KIND_FETCH)
        |-> SIZE_W'(r_div[DIV_STEPS].lx.work) < i_cfg.src_w)
        else $error("scaled column falls outside the source image");
    a_row_in_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div[DIV_STEPS].valid && (r_div[DIV_STEPS].kind == KIND_FETCH)
        |-> SIZE_W'(r_div[DIV_STEPS].ly.work) < i_cfg.src_h)
        else $error("scaled row falls outside the source image");
    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_in_range
        |-> (r_out_red == '0) && (r_out_green == '0) && (r_out_blue == '0)
            && (r_out_alpha == '0))
        else $error("out of range result carries nonzero data");
    a_clear_is_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_alpha == '0)
        |-> (r_out_red == '0) && (r_out_green == '0) && (r_out_blue == '0))
        else $error("transparent pixel kept its colour");
`endif

endmodule

/* sv/nearest_scale_premultiply_core.sv */
`timescale 1ns / 1ps

// Nearest-neighbor scaler with alpha premultiplication. The block holds a
// 128 x 128 source image of RGBA words in a store with one write port and one
// read port (no clearing pass; an entry must be written before it is
// fetched). A word with tuser 0 writes a source pixel; a word with tuser 1
// fetches pixel (dx, dy) of the square target and returns one result word with
// premultiplied color and an in-range flag. Writes and fetches stream at one
// word per clock while the output is not stalled; the seven-step pipelined
// divider that maps target to source coordinates and the one write and one
// read of the store per cycle set that figure. A fetch passes through the queue,
// the divider stages and the store read, multiply and output registers. A
// four-word queue between the classifying front end and the back end absorbs
// incoming words while a result waits; once it is full the input stalls.
// Configuration must be written only while the block is idle; it is not enforced.
module nearest_scale_premultiply_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // column[6:0], row[13:7], pixel_word[45:14], zero
    input  logic        i_s_axis_tuser,   // operation[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic        o_m_axis_tuser    // in_range[0]
);
    import nspm_pkg::*;

    logic [SIZE_W-1:0] r_src_w;
    logic [SIZE_W-1:0] r_src_h;
    logic [SIZE_W-1:0] r_target;
    t_cfg              cfg;

    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    t_cmd              cmd;
    t_cmd              head;

    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= SIZE_W'(128);
            r_src_h  <= SIZE_W'(128);
            r_target <= SIZE_W'(48);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SOURCE_WIDTH:  r_src_w  <= i_cfg_data;
                CFG_SOURCE_HEIGHT: r_src_h  <= i_cfg_data;
                CFG_TARGET_SIDE:   r_target <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Source sizes saturate to 1..MAX_SOURCE_SIDE, the target side to MAX_TARGET_SIDE.
    always_comb begin
        if (r_src_w == '0) begin
            cfg.src_w = SIZE_W'(1);
        end else if (r_src_w > SIZE_W'(MAX_SOURCE_SIDE)) begin
            cfg.src_w = SIZE_W'(MAX_SOURCE_SIDE);
        end else begin
            cfg.src_w = r_src_w;
        end
        if (r_src_h == '0) begin
            cfg.src_h = SIZE_W'(1);
        end else if (r_src_h > SIZE_W'(MAX_SOURCE_SIDE)) begin
            cfg.src_h = SIZE_W'(MAX_SOURCE_SIDE);
        end else begin
            cfg.src_h = r_src_h;
        end
        if (r_target > SIZE_W'(MAX_TARGET_SIDE)) begin
            cfg.target = SIZE_W'(MAX_TARGET_SIDE);
        end else begin
            cfg.target = r_target;
        end
    end

    nspm_front u_front (
        .i_cfg    (cfg),
        .i_valid  (i_s_axis_tvalid),
        .i_op     (i_s_axis_tuser),
        .i_column (i_s_axis_tdata[6:0]),
        .i_row    (i_s_axis_tdata[13:7]),
        .i_word   (i_s_axis_tdata[45:14]),
        .i_full   (q_full),
        .o_ready  (o_s_axis_tready),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    nspm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    nspm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_head     (head),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_red      (red),
        .o_green    (green),
        .o_blue     (blue),
        .o_alpha    (alpha),
        .o_in_range (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {alpha, blue, green, red};

endmodule

/* tb/sv/nearest_scale_premultiply_core_tb.sv */
`timescale 1ns / 1ps

module nearest_scale_premultiply_core_tb;
    import nspm_pkg::*;

    // The index past the last register; writes to it must be ignored.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic        op;
        logic [6:0]  col;
        logic [6:0]  row;
        logic [31:0] word;
    } t_scaler_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       in_range;
    } t_scaled_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = 48'd0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    nearest_scale_premultiply_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Register copies, the source image as the block should hold it, and the
    // set of entries already written by queued words.
    logic [7:0]  src_width_reg  = 8'd128;
    logic [7:0]  src_height_reg = 8'd128;
    logic [7:0]  target_reg     = 8'd48;
    logic [31:0] img_store [0:STORE_DEPTH-1];
    bit          img_written [0:STORE_DEPTH-1];

    t_scaler_word  pending_items [$];
    t_scaled_pixel expected_pixels [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit recv_hold = 1'b0;
    bit in_fire = 1'b0;
    int n_errors = 0;
    int n_accepted = 0;
    int n_writes = 0;
    int n_fetches = 0;
    int n_outside = 0;
    int n_settings = 0;

    function automatic int clamp_side(logic [7:0] v);
        if (v < 1) return 1;
        if (v > MAX_SOURCE_SIDE) return MAX_SOURCE_SIDE;
        return int'(v);
    endfunction

    function automatic int eff_target();
        return (target_reg > MAX_TARGET_SIDE) ? MAX_TARGET_SIDE : int'(target_reg);
    endfunction

    function automatic bit in_source(logic [6:0] col, logic [6:0] row);
        return (col < clamp_side(src_width_reg)) && (row < clamp_side(src_height_reg));
    endfunction

    // Maps a target pixel to its source store address; returns 0 when the
    // pixel lies outside the target square.
    function automatic bit map_to_source(input logic [6:0] col, input logic [6:0] row,
                                         output int addr);
        int w, h, t, sx, sy;
        w = clamp_side(src_width_reg);
        h = clamp_side(src_height_reg);
        t = eff_target();
        addr = 0;
        if (t == 0 || col >= t || row >= t) return 1'b0;
        sx = (int'(col) * w) / t;
        if (sx >= w) sx = w - 1;
        sy = (int'(row) * h) / t;
        if (sy >= h) sy = h - 1;
        addr = sy * MAX_SOURCE_SIDE + sx;
        return 1'b1;
    endfunction

    function automatic logic [7:0] premultiply(logic [7:0] c, logic [7:0] a);
        return 8'((int'(c) * int'(a)) / 255);
    endfunction

    function automatic logic [31:0] rand_pixel();
        logic [31:0] px;
        px = $urandom();
        case ($urandom_range(5))
            0: px[31:24] = 8'h00;
            1: px[31:24] = 8'hFF;
            default: ;
        endcase
        return px;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // Input side: a new word is offered once the previous one was taken.
    always @(negedge i_clk) begin : drive_words
        t_scaler_word nxt;
        bit give;
        if (!i_s_axis_tvalid || in_fire) begin
            give = 1'b0;
            if (i_rst_n && pending_items.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_items.pop_front();
                give = 1'b1;
            end
            if (give) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {2'b00, nxt.word, nxt.row, nxt.col};
                i_s_axis_tuser  <= nxt.op;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : watch_ports
        t_scaled_pixel want;
        logic [6:0]  col, row;
        logic [31:0] px;
        int addr;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                col = i_s_axis_tdata[6:0];
                row = i_s_axis_tdata[13:7];
                n_accepted++;
                if (i_s_axis_tuser == OP_FETCH) begin
                    n_fetches++;
                    want = '0;
                    if (map_to_source(col, row, addr)) begin
                        px = img_store[addr];
                        want.red      = premultiply(px[7:0], px[31:24]);
                        want.green    = premultiply(px[15:8], px[31:24]);
                        want.blue     = premultiply(px[23:16], px[31:24]);
                        want.alpha    = px[31:24];
                        want.in_range = 1'b1;
                    end else begin
                        n_outside++;
                    end
                    expected_pixels.insert(expected_pixels.size(), want);
                end else begin
                    n_writes++;
                    if (in_source(col, row))
                        img_store[int'(row) * MAX_SOURCE_SIDE + int'(col)] =
                            i_s_axis_tdata[45:14];
                end
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result word with no fetch pending: data %h, in_range %0b",
                           o_m_axis_tdata, o_m_axis_tuser);
                    n_errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("red", want.red, o_m_axis_tdata[7:0]);
                    check_field("green", want.green, o_m_axis_tdata[15:8]);
                    check_field("blue", want.blue, o_m_axis_tdata[23:16]);
                    check_field("alpha", want.alpha, o_m_axis_tdata[31:24]);
                    check_field("in_range", want.in_range, o_m_axis_tuser);
                end
            end
        end
    end

    task automatic queue_word(logic op, logic [6:0] col, logic [6:0] row, logic [31:0] word);
        pending_items.insert(pending_items.size(),
                             '{op: op, col: col, row: row, word: word});
        if (op == OP_WRITE && in_source(col, row))
            img_written[int'(row) * MAX_SOURCE_SIDE + int'(col)] = 1'b1;
    endtask

    // A fetch that would land on a never-written entry gets that entry
    // written first.
    task automatic queue_fetch(logic [6:0] col, logic [6:0] row);
        int addr;
        if (map_to_source(col, row, addr) && !img_written[addr])
            queue_word(OP_WRITE, 7'(addr % MAX_SOURCE_SIDE), 7'(addr / MAX_SOURCE_SIDE),
                       rand_pixel());
        queue_word(OP_FETCH, col, row, $urandom());
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        // Trailing writes give no result, so allow the pipeline to empty.
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SOURCE_WIDTH:  src_width_reg  = val;
            CFG_SOURCE_HEIGHT: src_height_reg = val;
            CFG_TARGET_SIDE:   target_reg     = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(int count);
        int w, h, t, r;
        logic [6:0] c, rw;
        w = clamp_side(src_width_reg);
        h = clamp_side(src_height_reg);
        t = eff_target();
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 45) begin
                if (t > 0 && r < 38) begin
                    c  = 7'($urandom_range(t - 1));
                    rw = 7'($urandom_range(t - 1));
                end else begin
                    c  = 7'($urandom_range(127));
                    rw = 7'($urandom_range(127));
                end
                queue_fetch(c, rw);
            end else if (r < 87) begin
                queue_word(OP_WRITE, 7'($urandom_range(w - 1)), 7'($urandom_range(h - 1)),
                           rand_pixel());
            end else begin
                queue_word(OP_WRITE, 7'($urandom_range(127)), 7'($urandom_range(127)),
                           rand_pixel());
            end
        end
    endtask

    task automatic run_phase(logic [7:0] w, logic [7:0] h, logic [7:0] t,
                             int send_pct, int recv_pct, int count, bit pause);
        wait_idle();
        write_reg(CFG_SOURCE_WIDTH, w);
        write_reg(CFG_SOURCE_HEIGHT, h);
        write_reg(CFG_TARGET_SIDE, t);
        n_settings++;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (pause) begin
            queue_random(count / 2);
            wait_idle();
            queue_random(count - count / 2);
        end else begin
            queue_random(count);
        end
    endtask

    // Long output stall while the input keeps offering words.
    initial begin : output_hold
        while (n_accepted < 300 || pending_items.size() < 50) @(posedge i_clk);
        recv_hold = 1'b1;
        repeat (400) @(posedge i_clk);
        recv_hold = 1'b0;
    end

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 9;
        recv_idle_pct = 84;
        n_settings = 1;

        // Reset sizes: corners of the target, alpha extremes, fetches off the square.
        queue_word(OP_WRITE, 7'd0, 7'd0, 32'hFFFF_FFFF);
        queue_fetch(7'd0, 7'd0);
        queue_word(OP_WRITE, 7'd125, 7'd125, 32'h00FF_FFFF);
        queue_fetch(7'd47, 7'd47);
        queue_word(OP_WRITE, 7'd2, 7'd0, 32'h80FF_4001);
        queue_fetch(7'd1, 7'd0);
        queue_word(OP_WRITE, 7'd127, 7'd127, 32'h0000_0000);
        queue_fetch(7'd48, 7'd0);
        queue_fetch(7'd0, 7'd48);
        queue_fetch(7'd127, 7'd127);

        // Zero sizes: one-column source and an empty target.
        wait_idle();
        write_reg(CFG_TARGET_SIDE, 8'd0);
        write_reg(CFG_SOURCE_WIDTH, 8'd0);
        write_reg(CFG_SOURCE_HEIGHT, 8'd255);
        write_reg(CFG_UNUSED, 8'h55);
        n_settings++;
        queue_word(OP_WRITE, 7'd1, 7'd0, 32'hDEAD_BEEF);
        queue_word(OP_WRITE, 7'd0, 7'd127, 32'h7F12_34FE);
        queue_fetch(7'd0, 7'd0);
        queue_fetch(7'd127, 7'd127);

        // Oversized target saturates to the largest side.
        wait_idle();
        write_reg(CFG_TARGET_SIDE, 8'd200);
        n_settings++;
        queue_fetch(7'd127, 7'd127);
        queue_fetch(7'd0, 7'd127);
        queue_word(OP_WRITE, 7'd127, 7'd0, 32'h1234_5678);

        run_phase(8'd128, 8'd128, 8'd128, 9, 84, 120, 1'b1);
        run_phase(8'd1,   8'd1,   8'd1,   9, 84, 80,  1'b0);
        run_phase(8'd37,  8'd53,  8'd90,  9, 84, 140, 1'b0);
        run_phase(8'd255, 8'd0,   8'd255, 84, 9, 110, 1'b0);
        run_phase(8'd7,   8'd100, 8'd3,   84, 9, 120, 1'b0);
        run_phase(8'd100, 8'd7,   8'd128, 84, 9, 130, 1'b0);
        run_phase(8'd128, 8'd128, 8'd1,   0,  0, 120, 1'b0);
        run_phase(8'd64,  8'd128, 8'd200, 0,  0, 150, 1'b0);
        run_phase(8'd17,  8'd120, 8'd60,  0,  0, 130, 1'b0);

        wait_idle();
        $display("Checked %0d fetch results (%0d outside the target) after %0d source writes",
                 n_fetches, n_outside, n_writes);
        $display("across %0d size settings, three idle mixes, a long output stall and a drain.",
                 n_settings);
        if (n_errors == 0) begin
            $display("PASS nearest_scale_premultiply_core");
        end else begin
            $display("FAIL nearest_scale_premultiply_core");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAIL nearest_scale_premultiply_core");
        $finish;
    end

endmodule

/* files.f */
sv/nspm_pkg.sv
sv/nspm_front.sv
sv/nspm_queue.sv
sv/nspm_back.sv
sv/nearest_scale_premultiply_core.sv
tb/sv/nearest_scale_premultiply_core_tb.sv
